// ===== hdl/efr_pkg.sv =====
// ----------------------------------------------------------------------------
// efr_pkg: shared types and constants of the escaped frame receiver
// Command and result formats, queue depths, register indexes and the
// byte-wide CRC-16/CCITT update.
// ----------------------------------------------------------------------------
package efr_pkg;

   // longest frame body kept, CRC bytes included
   localparam int MAX_LEN = 256;
   localparam int CNT_W   = $clog2(MAX_LEN + 1);

   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   localparam int RSP_DEPTH = 2;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   localparam logic [15:0] CRC_POLY = 16'h1021;

   // register indexes
   localparam logic [1:0] CSR_START  = 2'd0;
   localparam logic [1:0] CSR_END    = 2'd1;
   localparam logic [1:0] CSR_ESCAPE = 2'd2;
   localparam logic [1:0] CSR_SEED   = 2'd3;

   // command opcodes from front to back
   localparam logic [1:0] OP_DATA = 2'd0;
   localparam logic [1:0] OP_OPEN = 2'd1;
   localparam logic [1:0] OP_END  = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_ABORT = 2'd2;

   typedef struct packed {
      logic [1:0] op;
      logic       abort;   // OP_OPEN while a frame was open
      logic [7:0] data;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic       crc_good;
      logic [8:0] payload_length;
      logic       overflowed;
   } rsp_type;

   typedef struct packed {
      logic [7:0] sof_code;
      logic [7:0] eof_code;
      logic [7:0] esc_code;
   } delim_type;

   // MSB-first CRC-16 over one byte
   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== hdl/escaped_frame_receiver_crc16.sv =====
// ----------------------------------------------------------------------------
// escaped_frame_receiver_crc16: byte-stuffed frame receiver with CRC-16 check
//
// Raw link bytes enter on the req_ queue port: a transaction happens when
// req_push is high and req_full is low. Results leave on the rsp_ queue port:
// the oldest result sits on the rsp_ fields while rsp_empty is low and is
// taken when rsp_pop is high. Each result is a payload byte (delayed two bytes
// so the trailing CRC is never emitted), a frame end with CRC status, length
// and overflow flag, or an abort caused by a start byte inside a frame.
// One byte is accepted per cycle, sustained, while the sink keeps popping:
// the decoder and the executor each handle one byte per cycle and the CRC is
// updated a byte at a time. Each accepted byte is registered in the command
// queue, and its result in the result queue, before the result reaches rsp_.
// A 4-entry command queue sits between decoder and executor and a 2-entry
// result queue at the output; when the sink stops popping, these fill and
// req_full rises, and nothing is lost.
// Reset empties both queues, leaves the block outside a frame and loads the
// delimiter and seed registers with their defaults. csr_ writes take effect
// at once and are meant to happen while the block is idle.
// ----------------------------------------------------------------------------
module escaped_frame_receiver_crc16 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_crc_good,
   output logic [8:0]  rsp_payload_length,
   output logic        rsp_overflowed,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata
);
   import efr_pkg::*;

   delim_type   delim_ff;
   logic [15:0] seed_ff;

   logic        cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type     cmd_in, cmd_head;
   logic        rsp_push, rsp_full;
   rsp_type     rsp_in, rsp_head;
   logic        accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff.sof_code <= 8'd253;
         delim_ff.eof_code <= 8'd254;
         delim_ff.esc_code <= 8'd255;
         seed_ff           <= 16'hFFFF;
      end else if (csr_wr_en) begin
         case (csr_addr)
            CSR_START:  delim_ff.sof_code <= csr_wdata[7:0];
            CSR_END:    delim_ff.eof_code <= csr_wdata[7:0];
            CSR_ESCAPE: delim_ff.esc_code <= csr_wdata[7:0];
            CSR_SEED:   seed_ff           <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req_full = cmd_full;
   assign accept   = req_push && !cmd_full;

   efr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .rx_byte  (req_rx_byte),
      .delim    (delim_ff),
      .cmd_push (cmd_push),
      .cmd      (cmd_in)
   );

   efr_cmd_queue u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_in),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rdata (cmd_head),
      .empty (cmd_empty)
   );

   efr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd       (cmd_head),
      .cmd_pop   (cmd_pop),
      .crc_seed  (seed_ff),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_in)
   );

   efr_rsp_queue u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_in),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .rdata (rsp_head),
      .empty (rsp_empty)
   );

   assign rsp_kind           = rsp_head.kind;
   assign rsp_data_byte      = rsp_head.data_byte;
   assign rsp_crc_good       = rsp_head.crc_good;
   assign rsp_payload_length = rsp_head.payload_length;
   assign rsp_overflowed     = rsp_head.overflowed;

endmodule

// ===== hdl/efr_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// efr_cmd_queue: command queue between decoder and executor
// Small flop queue; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module efr_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  efr_pkg::cmd_type wdata,
   output logic             full,
   input  logic             pop,
   output efr_pkg::cmd_type rdata,
   output logic             empty
);
   import efr_pkg::*;

   cmd_type                mem_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign full    = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   // depth is a power of two, pointers wrap on their own
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== hdl/efr_rsp_queue.sv =====
// ----------------------------------------------------------------------------
// efr_rsp_queue: result queue at the output
// Holds finished results so the executor keeps running while the sink waits.
// ----------------------------------------------------------------------------
module efr_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  efr_pkg::rsp_type wdata,
   output logic             full,
   input  logic             pop,
   output efr_pkg::rsp_type rdata,
   output logic             empty
);
   import efr_pkg::*;

   rsp_type                mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign full    = (count_ff == RSP_CNT_W'(RSP_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== hdl/efr_front.sv =====
// ----------------------------------------------------------------------------
// efr_front: byte decoder
// Tracks frame and escape state, turns raw link bytes into open, end and
// data commands for the executor.
// ----------------------------------------------------------------------------
module efr_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         rx_byte,
   input  efr_pkg::delim_type delim,
   output logic               cmd_push,
   output efr_pkg::cmd_type   cmd
);
   import efr_pkg::*;

   logic in_frame_ff, in_frame_in;
   logic esc_pend_ff, esc_pend_in;
   logic is_start, is_end, is_esc;

   assign is_start = (rx_byte == delim.sof_code);
   assign is_end   = (rx_byte == delim.eof_code);
   assign is_esc   = (rx_byte == delim.esc_code);

   always_comb begin
      in_frame_in = in_frame_ff;
      esc_pend_in = esc_pend_ff;
      cmd_push    = 1'b0;
      cmd.op      = OP_DATA;
      cmd.abort   = 1'b0;
      cmd.data    = rx_byte;
      if (accept) begin
         if (esc_pend_ff) begin
            // only delimiters may be escaped, anything else is dropped
            esc_pend_in = 1'b0;
            cmd_push    = is_start || is_end || is_esc;
         end else if (is_start) begin
            cmd_push    = 1'b1;
            cmd.op      = OP_OPEN;
            cmd.abort   = in_frame_ff;
            in_frame_in = 1'b1;
         end else if (in_frame_ff) begin
            if (is_end) begin
               cmd_push    = 1'b1;
               cmd.op      = OP_END;
               in_frame_in = 1'b0;
            end else if (is_esc) begin
               esc_pend_in = 1'b1;
            end else begin
               cmd_push = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         esc_pend_ff <= 1'b0;
      end else begin
         in_frame_ff <= in_frame_in;
         esc_pend_ff <= esc_pend_in;
      end
   end

endmodule

// ===== hdl/efr_back.sv =====
// ----------------------------------------------------------------------------
// efr_back: frame executor
// Keeps the two-byte holdback, byte count, overflow flag and running CRC,
// and builds one result per command where the command calls for one.
// ----------------------------------------------------------------------------
module efr_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_empty,
   input  efr_pkg::cmd_type cmd,
   output logic             cmd_pop,
   input  logic [15:0]      crc_seed,
   input  logic             rsp_full,
   output logic             rsp_push,
   output efr_pkg::rsp_type rsp
);
   import efr_pkg::*;

   logic [7:0]       held0_ff, held0_in;   // older of the two
   logic [7:0]       held1_ff, held1_in;
   logic [15:0]      crc_ff, crc_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] plen;
   logic             have_crc;

   assign have_crc = (count_ff >= CNT_W'(2));
   assign plen     = have_crc ? count_ff - CNT_W'(2) : '0;
   assign cmd_pop  = !cmd_empty && !rsp_full;

   always_comb begin
      held0_in = held0_ff;
      held1_in = held1_ff;
      crc_in   = crc_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      rsp_push = 1'b0;
      rsp      = '0;
      if (cmd_pop) begin
         case (cmd.op)
            OP_OPEN: begin
               held0_in = '0;
               held1_in = '0;
               crc_in   = crc_seed;
               count_in = '0;
               ovf_in   = 1'b0;
               rsp_push = cmd.abort;
               rsp.kind = KIND_ABORT;
            end
            OP_END: begin
               rsp_push           = 1'b1;
               rsp.kind           = KIND_END;
               rsp.crc_good       = have_crc && !ovf_ff && ({held0_ff, held1_ff} == crc_ff);
               rsp.payload_length = 9'(plen);
               rsp.overflowed     = ovf_ff;
            end
            OP_DATA: begin
               if (count_ff == CNT_W'(MAX_LEN)) begin
                  ovf_in = 1'b1;
               end else begin
                  count_in = count_ff + 1'b1;
                  if (have_crc) begin
                     // oldest held byte is now known to be payload
                     crc_in        = crc_update(crc_ff, held0_ff);
                     rsp_push      = 1'b1;
                     rsp.kind      = KIND_DATA;
                     rsp.data_byte = held0_ff;
                     held0_in      = held1_ff;
                     held1_in      = cmd.data;
                  end else if (count_ff[0]) begin
                     held1_in = cmd.data;
                  end else begin
                     held0_in = cmd.data;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      held0_ff <= held0_in;
      held1_ff <= held1_in;
      crc_ff   <= crc_in;
   end

endmodule
